// File: src/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

  localparam int unsigned NUM_FRAMES    = 262144;
  localparam int unsigned FRAME_BYTES   = 4096;
  localparam int unsigned FRAME_W       = $clog2(NUM_FRAMES);
  localparam int unsigned INDEX_W       = FRAME_W + 1;
  localparam int unsigned OFF_W         = $clog2(FRAME_BYTES);
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned BIT_W         = $clog2(WORD_BITS);
  localparam int unsigned WORDS         = NUM_FRAMES / WORD_BITS;
  localparam int unsigned WA_W          = FRAME_W - BIT_W;
  localparam int unsigned KIB_PER_FRAME = FRAME_BYTES / 1024;

  localparam int unsigned ADDR_W  = 30;
  localparam int unsigned COUNT_W = 19;
  localparam int unsigned KIB_W   = 21;

  localparam logic [63:0] LOW_CUT     = 64'h100000;
  localparam logic [63:0] TOP_BYTES   = 64'(NUM_FRAMES) * 64'(FRAME_BYTES);
  localparam logic [31:0] AVAIL_TYPE  = 32'd1;

  localparam logic [2:0] KIND_RESET   = 3'd0;
  localparam logic [2:0] KIND_FREE_RG = 3'd1;
  localparam logic [2:0] KIND_RESV_RG = 3'd2;
  localparam logic [2:0] KIND_ALLOC   = 3'd3;
  localparam logic [2:0] KIND_FREE_FR = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] region_start;
    logic [63:0] region_length;
    logic [63:0] region_end;
    logic [31:0] region_type;
    logic [63:0] release_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  granted_address;
    logic               granted;
    logic [COUNT_W-1:0] free_count;
    logic [KIB_W-1:0]   free_kib;
  } out_t;

  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic bnd1;
    logic bnd2;
    logic rd;
    logic modify;
    logic alloc_start;
    logic alloc_mod;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       type_ok;
    logic       no_free;
    logic       clr_last;
    logic       rng_ok;
    logic       walk_last;
    logic       hit;
    logic       out_free;
  } stat_t;

endpackage

// File: src/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
module bfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bfa_pkg::stat_t stat,
  output bfa_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_CLR_RST  = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_DISP     = 11'b00000000100,
    S_BND1     = 11'b00000001000,
    S_BND2     = 11'b00000010000,
    S_RD       = 11'b00000100000,
    S_MOD      = 11'b00001000000,
    S_ARD      = 11'b00010000000,
    S_AMOD     = 11'b00100000000,
    S_CLR_ITEM = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLR_RST: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.kind) inside
          bfa_pkg::KIND_RESET: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR_ITEM;
          end
          bfa_pkg::KIND_FREE_RG: state_nxt = stat.type_ok ? S_BND1 : S_DONE;
          bfa_pkg::KIND_RESV_RG, bfa_pkg::KIND_FREE_FR: state_nxt = S_BND1;
          bfa_pkg::KIND_ALLOC: begin
            if (stat.no_free) begin
              state_nxt = S_DONE;
            end else begin
              cmd.alloc_start = 1'b1;
              state_nxt       = S_ARD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_BND1: begin
        cmd.bnd1  = 1'b1;
        state_nxt = S_BND2;
      end
      S_BND2: begin
        cmd.bnd2  = 1'b1;
        state_nxt = stat.rng_ok ? S_RD : S_DONE;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.modify = 1'b1;
        state_nxt  = stat.walk_last ? S_DONE : S_RD;
      end
      S_ARD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_AMOD;
      end
      S_AMOD: begin
        cmd.alloc_mod = 1'b1;
        state_nxt     = stat.hit ? S_DONE : S_ARD;
      end
      S_CLR_ITEM: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR_RST;
    endcase
  end

endmodule

// File: src/bfa_datapath.sv
// Datapath of the bitmap frame allocator: bitmap memory, counters and result register.
module bfa_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  bfa_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bfa_pkg::out_t  out_data,
  input  bfa_pkg::cmd_t  cmd,
  output bfa_pkg::stat_t stat
);

  localparam int unsigned FW = bfa_pkg::FRAME_W;
  localparam int unsigned IW = bfa_pkg::INDEX_W;
  localparam int unsigned BW = bfa_pkg::BIT_W;
  localparam int unsigned AW = bfa_pkg::WA_W;
  localparam int unsigned OW = bfa_pkg::OFF_W;
  localparam int unsigned WB = bfa_pkg::WORD_BITS;
  localparam int unsigned XW = 64 - OW + 1;

  logic [WB-1:0] mem [bfa_pkg::WORDS];
  logic [WB-1:0] rdata_r;
  logic          mem_we;
  logic [WB-1:0] mem_wdata;

  bfa_pkg::in_t               in_r;
  logic [63:0]                e_r;
  logic [IW-1:0]              lo_r, hi_r;
  logic                       set_r;
  logic [AW-1:0]              word_r;
  logic                       first_r;
  logic [bfa_pkg::COUNT_W-1:0] free_r;
  logic [FW-1:0]              ss_r;
  logic [bfa_pkg::ADDR_W-1:0] addr_r;
  logic                       ok_r;
  bfa_pkg::out_t              out_r;
  logic                       out_valid_r;

  function automatic logic [BW:0] popcount(input logic [WB-1:0] v);
    logic [BW:0] n;
    n = '0;
    for (int i = 0; i < WB; i++) n = n + (BW+1)'(v[i]);
    return n;
  endfunction

  // Region bounds in frames.
  logic [IW-1:0] b_lo, b_hi;
  logic          b_ok;
  always_comb begin
    logic [63:0] s_c, e_c;
    logic [XW-1:0] f0, f1;
    logic skip;
    s_c = '0; e_c = '0; f0 = '0; f1 = '0; skip = 1'b0;
    b_lo = '0; b_hi = '0; b_ok = 1'b0;
    case (in_r.kind)
      bfa_pkg::KIND_FREE_RG: begin
        s_c = in_r.region_start;
        e_c = e_r;
        if (in_r.region_start < bfa_pkg::LOW_CUT) begin
          if (e_r <= bfa_pkg::LOW_CUT) skip = 1'b1;
          s_c = bfa_pkg::LOW_CUT;
        end
        if (e_r > bfa_pkg::TOP_BYTES) begin
          if (s_c >= bfa_pkg::TOP_BYTES) skip = 1'b1;
          e_c = bfa_pkg::TOP_BYTES;
        end
        f0 = XW'(s_c[63:OW]) + XW'(|s_c[OW-1:0]);
        f1 = XW'(e_c[63:OW]);
        b_ok = !skip && (f0 < f1);
        b_lo = f0[IW-1:0];
        b_hi = f1[IW-1:0];
      end
      bfa_pkg::KIND_RESV_RG: begin
        f0 = XW'(in_r.region_start[63:OW]);
        f1 = XW'(in_r.region_end[63:OW]) + XW'(|in_r.region_end[OW-1:0]);
        if (f1 > XW'(bfa_pkg::NUM_FRAMES)) f1 = XW'(bfa_pkg::NUM_FRAMES);
        b_ok = (f0 < XW'(bfa_pkg::NUM_FRAMES)) && (f0 < f1);
        b_lo = f0[IW-1:0];
        b_hi = f1[IW-1:0];
      end
      bfa_pkg::KIND_FREE_FR: begin
        f0 = XW'(in_r.release_address[63:OW]);
        b_ok = f0 < XW'(bfa_pkg::NUM_FRAMES);
        b_lo = f0[IW-1:0];
        b_hi = f0[IW-1:0] + IW'(1);
      end
      default: b_ok = 1'b0;
    endcase
  end

  // Masked read-modify-write of one bitmap word.
  logic [IW-1:0] hm1;
  logic [WB-1:0] w_mask, w_chg, w_new;
  logic [BW:0]   w_cnt;
  always_comb begin
    hm1    = hi_r - IW'(1);
    w_mask = '1;
    if (word_r == lo_r[FW-1:BW]) w_mask = w_mask & ({WB{1'b1}} << lo_r[BW-1:0]);
    if (word_r == hm1[FW-1:BW])
      w_mask = w_mask & ({WB{1'b1}} >> (BW'(WB-1) - hm1[BW-1:0]));
    w_chg = set_r ? (~rdata_r & w_mask) : (rdata_r & w_mask);
    w_new = set_r ? (rdata_r | w_mask) : (rdata_r & ~w_mask);
    w_cnt = popcount(w_chg);
  end

  // Allocation search within one word.
  logic [WB-1:0] a_cand;
  logic [BW-1:0] a_bit;
  logic [FW-1:0] a_frame;
  always_comb begin
    a_cand = ~rdata_r;
    if (first_r) a_cand = a_cand & ({WB{1'b1}} << ss_r[BW-1:0]);
    a_bit = '0;
    for (int i = WB - 1; i >= 0; i--) if (a_cand[i]) a_bit = BW'(i);
    a_frame = {word_r, a_bit};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = w_new;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_wdata = '1;
    end else if (cmd.modify) begin
      mem_we = 1'b1;
    end else if (cmd.alloc_mod && (a_cand != '0)) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r | (WB'(1) << a_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[word_r] <= mem_wdata;
    if (cmd.rd) rdata_r <= mem[word_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.bnd1) begin
      logic [64:0] sum;
      sum = {1'b0, in_r.region_start} + {1'b0, in_r.region_length};
      e_r <= sum[64] ? '1 : sum[63:0];
    end
    if (cmd.bnd2) begin
      lo_r  <= b_lo;
      hi_r  <= b_hi;
      set_r <= (in_r.kind == bfa_pkg::KIND_RESV_RG);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      first_r     <= 1'b0;
      free_r      <= '0;
      ss_r        <= '0;
      addr_r      <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        addr_r <= '0;
        ok_r   <= 1'b0;
      end
      if (cmd.clr_start) begin
        word_r <= '0;
        free_r <= '0;
        ss_r   <= '0;
      end
      if (cmd.clr_step) word_r <= word_r + AW'(1);
      if (cmd.bnd2) word_r <= b_lo[FW-1:BW];
      if (cmd.modify) begin
        word_r <= word_r + AW'(1);
        if (set_r) free_r <= free_r - bfa_pkg::COUNT_W'(w_cnt);
        else       free_r <= free_r + bfa_pkg::COUNT_W'(w_cnt);
      end
      if (cmd.alloc_start) begin
        word_r  <= ss_r[FW-1:BW];
        first_r <= 1'b1;
      end
      if (cmd.alloc_mod) begin
        if (a_cand != '0) begin
          free_r <= free_r - bfa_pkg::COUNT_W'(1);
          ss_r   <= a_frame + FW'(1);
          addr_r <= bfa_pkg::ADDR_W'({a_frame, {OW{1'b0}}});
          ok_r   <= 1'b1;
        end else begin
          word_r  <= word_r + AW'(1);
          first_r <= 1'b0;
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.granted_address <= addr_r;
      out_r.granted         <= ok_r;
      out_r.free_count      <= free_r;
      out_r.free_kib        <= bfa_pkg::KIB_W'(free_r) * bfa_pkg::KIB_W'(bfa_pkg::KIB_PER_FRAME);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.kind      = in_r.kind;
  assign stat.type_ok   = (in_r.region_type == bfa_pkg::AVAIL_TYPE);
  assign stat.no_free   = (free_r == '0);
  assign stat.clr_last  = (word_r == AW'(bfa_pkg::WORDS - 1));
  assign stat.rng_ok    = b_ok;
  assign stat.walk_last = (word_r == hm1[FW-1:BW]);
  assign stat.hit       = (a_cand != '0);
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

// File: src/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: controller plus datapath.
//
// Next-fit page frame allocator over a bitmap of 262144 frames of 4 KiB held
// in a 4096 x 64-bit memory. Each input transfer produces exactly one result
// transfer carrying the free count after the item. Items are handled one at a
// time; the result register lets the next item be taken while a result still
// waits. After reset, and for every reset-all item, a clearing pass writes
// all 4096 words to used, one word per cycle, so the block takes no item
// after reset until that pass is done. Each item is sequenced over the
// single memory port: a frame release, region free or reserve works out its
// frame bounds and then reads and writes back each bitmap word they cover in
// turn, and an allocate reads and searches words from the cursor until one
// holds a free frame (an allocate with no free frames does no search).
module bitmap_frame_allocator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bfa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bfa_pkg::out_t out_data
);

  bfa_pkg::cmd_t  cmd;
  bfa_pkg::stat_t stat;

  // The controller sequences each item; the datapath does the memory work.
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: verif/bitmap_frame_allocator_test.sv
// Self-checking testbench of the bitmap frame allocator with a scoreboard class.
`timescale 1ns / 1ps

module bitmap_frame_allocator_test;

  localparam int unsigned RANDOM_ITEMS = 1800;
  // No transfer for this many cycles means the block is hung. The slowest
  // correct item is a full-map scan or a clearing pass.
  localparam int unsigned IDLE_LIMIT = 60000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // The scoreboard keeps its own image of the bitmap, the free counter and
  // the next-fit cursor, and it queues one expected result per input transfer.
  class frame_scoreboard;
    logic [63:0]        bitmap[bfa_pkg::WORDS];
    int unsigned        free_cnt;
    int unsigned        cursor;
    bfa_pkg::out_t      pending[$];
    int unsigned        failures;
    int unsigned        checked;
    int unsigned        grants;

    function new();
      failures = 0;
      checked = 0;
      grants = 0;
      clear_all();
    endfunction

    function void clear_all();
      foreach (bitmap[w]) bitmap[w] = '1;
      free_cnt = 0;
      cursor = 0;
    endfunction

    function void mark_frame(longint unsigned f);
      if (!bitmap[f[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]][f[bfa_pkg::BIT_W-1:0]]) begin
        bitmap[f[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]][f[bfa_pkg::BIT_W-1:0]] = 1'b1;
        free_cnt--;
      end
    endfunction

    function void release_frame(longint unsigned f);
      if (bitmap[f[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]][f[bfa_pkg::BIT_W-1:0]]) begin
        bitmap[f[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]][f[bfa_pkg::BIT_W-1:0]] = 1'b0;
        free_cnt++;
      end
    endfunction

    function void free_span(logic [63:0] s, logic [63:0] len, logic [31:0] rtype);
      logic [64:0]     sum;
      logic [63:0]     e;
      longint unsigned f0, f1;
      if (rtype != bfa_pkg::AVAIL_TYPE) return;
      sum = {1'b0, s} + {1'b0, len};
      e = sum[64] ? '1 : sum[63:0];
      if (s < bfa_pkg::LOW_CUT) begin
        if (e <= bfa_pkg::LOW_CUT) return;
        s = bfa_pkg::LOW_CUT;
      end
      if (e > bfa_pkg::TOP_BYTES) begin
        if (s >= bfa_pkg::TOP_BYTES) return;
        e = bfa_pkg::TOP_BYTES;
      end
      // Round inward: the first frame is rounded up and the end down.
      f0 = s / bfa_pkg::FRAME_BYTES + ((s % bfa_pkg::FRAME_BYTES) != 0);
      f1 = e / bfa_pkg::FRAME_BYTES;
      for (longint unsigned f = f0; f < f1 && f < bfa_pkg::NUM_FRAMES; f++)
        release_frame(f);
    endfunction

    function void reserve_span(logic [63:0] s, logic [63:0] e);
      longint unsigned f0, f1;
      f0 = s / bfa_pkg::FRAME_BYTES;
      f1 = e / bfa_pkg::FRAME_BYTES + ((e % bfa_pkg::FRAME_BYTES) != 0);
      if (f0 >= bfa_pkg::NUM_FRAMES) return;
      if (f1 > bfa_pkg::NUM_FRAMES) f1 = bfa_pkg::NUM_FRAMES;
      for (longint unsigned f = f0; f < f1; f++) mark_frame(f);
    endfunction

    // Next-fit scan a word at a time. The first word is visited twice: bits
    // at and above the cursor first, the bits below it after the wrap.
    function void grab_frame(output logic ok, output longint unsigned addr);
      int unsigned w0, b0, w;
      logic [63:0] avail;
      ok = 1'b0;
      addr = 0;
      w0 = cursor / bfa_pkg::WORD_BITS;
      b0 = cursor % bfa_pkg::WORD_BITS;
      for (int unsigned n = 0; n <= bfa_pkg::WORDS && !ok; n++) begin
        w = (w0 + n) % bfa_pkg::WORDS;
        avail = ~bitmap[w];
        if (n == 0) avail &= ~((64'd1 << b0) - 64'd1);
        if (n == bfa_pkg::WORDS) avail &= (64'd1 << b0) - 64'd1;
        if (avail != 0) begin
          for (int unsigned b = 0; b < bfa_pkg::WORD_BITS && !ok; b++) begin
            if (avail[b]) begin
              ok = 1'b1;
              addr = longint'(w) * bfa_pkg::WORD_BITS + b;
            end
          end
        end
      end
      if (ok) begin
        mark_frame(addr);
        cursor = (addr + 1) % bfa_pkg::NUM_FRAMES;
        addr = addr * bfa_pkg::FRAME_BYTES;
      end
    endfunction

    function void note_input(bfa_pkg::in_t item);
      bfa_pkg::out_t   r;
      logic            ok;
      longint unsigned addr;
      ok = 1'b0;
      addr = 0;
      case (item.kind)
        bfa_pkg::KIND_RESET:   clear_all();
        bfa_pkg::KIND_FREE_RG: free_span(item.region_start, item.region_length,
                                         item.region_type);
        bfa_pkg::KIND_RESV_RG: reserve_span(item.region_start, item.region_end);
        bfa_pkg::KIND_ALLOC:   grab_frame(ok, addr);
        bfa_pkg::KIND_FREE_FR: begin
          if (item.release_address / bfa_pkg::FRAME_BYTES < bfa_pkg::NUM_FRAMES)
            release_frame(item.release_address / bfa_pkg::FRAME_BYTES);
        end
        default: ;
      endcase
      r.granted_address = addr[bfa_pkg::ADDR_W-1:0];
      r.granted = ok;
      r.free_count = free_cnt[bfa_pkg::COUNT_W-1:0];
      r.free_kib = bfa_pkg::KIB_W'(free_cnt * bfa_pkg::KIB_PER_FRAME);
      pending.push_back(r);
    endfunction

    function void check_result(bfa_pkg::out_t got);
      bfa_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no expected result waiting");
        failures++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.granted) grants++;
      if (got.granted_address !== want.granted_address) begin
        $error("granted_address: expected %0h, actual %0h",
               want.granted_address, got.granted_address);
        failures++;
      end
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, actual %0d", want.granted, got.granted);
        failures++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
        failures++;
      end
      if (got.free_kib !== want.free_kib) begin
        $error("free_kib: expected %0d, actual %0d", want.free_kib, got.free_kib);
        failures++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  bfa_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall;
  bfa_pkg::out_t  out_data;

  frame_scoreboard sb;
  bfa_pkg::in_t    stimulus[$];
  int unsigned     idle_cycles;

  bitmap_frame_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bfa_pkg::in_t make_item(logic [2:0] kind, logic [63:0] s,
                                             logic [63:0] len, logic [63:0] e,
                                             logic [31:0] rtype, logic [63:0] rel);
    bfa_pkg::in_t it;
    it.kind = kind;
    it.region_start = s;
    it.region_length = len;
    it.region_end = e;
    it.region_type = rtype;
    it.release_address = rel;
    return it;
  endfunction

  // Byte address somewhere in managed memory, mostly above the low cut, on
  // a frame boundary half the time and with a random offset otherwise.
  function automatic logic [63:0] pick_address();
    logic [63:0] a;
    if ($urandom_range(0, 9) == 0) a = 64'($urandom_range(0, 255)) * bfa_pkg::FRAME_BYTES;
    else a = 64'($urandom_range(256, bfa_pkg::NUM_FRAMES - 1)) * bfa_pkg::FRAME_BYTES;
    if ($urandom_range(0, 1)) a += $urandom_range(0, bfa_pkg::FRAME_BYTES - 1);
    return a;
  endfunction

  task automatic build_directed();
    // Everything is used after reset: an allocate must fail first.
    stimulus.push_back(make_item(bfa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, bfa_pkg::LOW_CUT, 64'h40000, 0,
                                 bfa_pkg::AVAIL_TYPE, 0));
    // Region of a type other than available is ignored.
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, 64'h200000, 64'h10000, 0, '1, 0));
    // Region straddling the low cut; only the part above it is freed.
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, 64'h0, 64'h102000, 0,
                                 bfa_pkg::AVAIL_TYPE, 0));
    // Unaligned region rounded inward to whole frames.
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, 64'h300001, 64'h3000, 0,
                                 bfa_pkg::AVAIL_TYPE, 0));
    // Overflowing start plus length saturates; this start lies above the top.
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, '1, '1, 0, bfa_pkg::AVAIL_TYPE, 0));
    // Overflow near the top saturates and is then capped at the top.
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, 64'h3FFF0000, '1, 0,
                                 bfa_pkg::AVAIL_TYPE, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_FR, 0, 0, 0, 0, 64'h100FFF));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_FR, 0, 0, 0, 0, 64'h100000));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_FR, 0, 0, 0, 0, '1));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_FR, 0, 0, 0, 0, 64'h0));
    // Reserve rounds outward; one past the top is ignored, the end is clamped.
    stimulus.push_back(make_item(bfa_pkg::KIND_RESV_RG, 64'h101001, 0, 64'h104001, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_RESV_RG, bfa_pkg::TOP_BYTES, 0, '1, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_RESV_RG, 64'h3FFFE000, 0, '1, 0, 0));
    // Empty and inverted regions do nothing.
    stimulus.push_back(make_item(bfa_pkg::KIND_RESV_RG, 64'h500000, 0, 64'h400000, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, 64'h500000, 0, 0,
                                 bfa_pkg::AVAIL_TYPE, 0));
    stimulus.push_back(make_item(3'd5, '1, '1, '1, '1, '1));
    stimulus.push_back(make_item(3'd6, 0, 0, 0, 0, 0));
    stimulus.push_back(make_item(3'd7, 0, 0, 0, 0, 0));
    // Only the last frame free: the cursor must wrap to zero after it.
    stimulus.push_back(make_item(bfa_pkg::KIND_RESET, 0, 0, 0, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_FREE_FR, 0, 0, 0, 0,
                                 bfa_pkg::TOP_BYTES - 1));
    stimulus.push_back(make_item(bfa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0));
    stimulus.push_back(make_item(bfa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0));
  endtask

  task automatic build_random();
    int unsigned pick;
    logic [63:0] s, len;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      s = pick_address();
      // Regions are mostly a few frames; a few cover thousands.
      if ($urandom_range(0, 49) == 0)
        len = 64'($urandom_range(0, 4096)) * bfa_pkg::FRAME_BYTES;
      else
        len = 64'($urandom_range(0, 96)) * bfa_pkg::FRAME_BYTES;
      if ($urandom_range(0, 1)) len += $urandom_range(0, bfa_pkg::FRAME_BYTES - 1);
      if (pick < 1)
        stimulus.push_back(make_item(bfa_pkg::KIND_RESET, rand64(), rand64(), rand64(),
                                     $urandom, rand64()));
      else if (pick < 22)
        stimulus.push_back(make_item(bfa_pkg::KIND_FREE_RG, s, len, rand64(),
                                     ($urandom_range(0, 9) == 0) ? $urandom
                                                                 : bfa_pkg::AVAIL_TYPE,
                                     rand64()));
      else if (pick < 32)
        stimulus.push_back(make_item(bfa_pkg::KIND_RESV_RG, s, rand64(), s + (len >> 2),
                                     $urandom, rand64()));
      else if (pick < 65)
        stimulus.push_back(make_item(bfa_pkg::KIND_ALLOC, rand64(), rand64(), rand64(),
                                     $urandom, rand64()));
      else if (pick < 90)
        stimulus.push_back(make_item(bfa_pkg::KIND_FREE_FR, rand64(), rand64(), rand64(),
                                     $urandom, pick_address()));
      else if (pick < 95)
        // Noise with full-width fields; huge regions are mostly clipped away.
        stimulus.push_back(make_item(3'($urandom_range(1, 4)), rand64(), rand64(),
                                     rand64(), $urandom_range(0, 2), rand64()));
      else
        stimulus.push_back(make_item(3'($urandom_range(5, 7)), rand64(), rand64(),
                                     rand64(), $urandom, rand64()));
    end
  endtask

  // Sender: bursts of back-to-back transfers separated by random gaps. Valid
  // stays high across a burst and is only dropped when a real gap follows.
  task automatic send_all();
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    foreach (stimulus[i]) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      in_valid <= 1'b1;
      in_data <= stimulus[i];
      do @(posedge clk); while (in_stall);
      burst_left--;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: picks its stall pattern afresh for each run of random length, among
  // never stalling, random stalls, and long stall runs.
  initial begin
    int unsigned mode, run;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      run = $urandom_range(50, 300);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 19) != 0);
        endcase
      end
    end
  end

  // Transfers are sampled at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    build_directed();
    build_random();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_all();
    // A late reset-all item still has its clearing pass to run, so wait for every expected result.
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d items, %0d directed; checked %0d results, %0d with a granted frame.",
             stimulus.size(), stimulus.size() - RANDOM_ITEMS, sb.checked, sb.grants);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.failures, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
